// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands. Each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ptcta_pkg.sv -----
// ----------------------------------------------------------------------------
// ptcta_pkg
// Shared types and constants of the per-task CPU time accounting unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptcta_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 4096;
  localparam int unsigned ID_W           = 12;
  localparam int unsigned STAMP_W        = 64;
  localparam int unsigned CNT_W          = 32;

  // request codes
  localparam logic REQ_SWITCH = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // one word of the stamp memory
  typedef struct packed {
    logic               run_valid;
    logic [STAMP_W-1:0] run_stamp;
    logic               wait_valid;
    logic [STAMP_W-1:0] wait_stamp;
  } stamp_entry_t;

  // one word of the statistics memory
  typedef struct packed {
    logic               valid;
    logic [CNT_W-1:0]   switches;
    logic [STAMP_W-1:0] run_total;
    logic [STAMP_W-1:0] last_wait;
  } stat_entry_t;

  // memory strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic stamp_we;
    logic stat_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- src/ptcta_ram.sv -----
// ----------------------------------------------------------------------------
// ptcta_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcta_ram #(
  parameter int unsigned DEPTH = ptcta_pkg::TASK_SLOTS_DEF,
  parameter int unsigned WIDTH = $bits(ptcta_pkg::stat_entry_t),
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/ptcta_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptcta_ctrl
// Sequencer and update datapath: reads, modifies and writes back the stamp
// and statistics entries of the outgoing and incoming task, serves queries, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptcta_ctrl #(
  parameter int unsigned TASK_SLOTS = ptcta_pkg::TASK_SLOTS_DEF,
  localparam int unsigned IDX_W     = $clog2(TASK_SLOTS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [ptcta_pkg::STAMP_W-1:0]    now_ns_i,
  input  logic [ptcta_pkg::ID_W-1:0]       prev_task_i,
  input  logic [ptcta_pkg::ID_W-1:0]       next_task_i,
  input  logic [ptcta_pkg::ID_W-1:0]       query_task_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ptcta_pkg::STAMP_W-1:0]    oncpu_delta_o,
  output logic                             oncpu_seen_o,
  output logic [ptcta_pkg::STAMP_W-1:0]    runq_delta_o,
  output logic                             runq_seen_o,
  output logic                             stat_found_o,
  output logic [ptcta_pkg::CNT_W-1:0]      stat_switches_o,
  output logic [ptcta_pkg::STAMP_W-1:0]    stat_oncpu_total_o,
  output logic [ptcta_pkg::STAMP_W-1:0]    stat_last_runq_o,
  // memory side
  output ptcta_pkg::mem_ctl_t              mem_ctl_o,
  output logic [IDX_W-1:0]                 rd_addr_o,
  output logic [IDX_W-1:0]                 wr_addr_o,
  output ptcta_pkg::stamp_entry_t          stamp_wdata_o,
  output ptcta_pkg::stat_entry_t           stat_wdata_o,
  input  ptcta_pkg::stamp_entry_t          stamp_rdata_i,
  input  ptcta_pkg::stat_entry_t           stat_rdata_i
);

  import ptcta_pkg::*;

  localparam int unsigned EXT_W = ((ID_W > IDX_W) ? ID_W : IDX_W) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREV_WB,
    ST_NEXT_RD,
    ST_NEXT_WB,
    ST_QRY_WB
  } state_e;

  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    return EXT_W'(id) < EXT_W'(TASK_SLOTS);
  endfunction

  function automatic logic [IDX_W-1:0] id_to_idx(input logic [ID_W-1:0] id);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(id);
    return ext[IDX_W-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    clr_idx_q, clr_idx_d;
  logic [STAMP_W-1:0]  now_q, now_d;
  logic [IDX_W-1:0]    prev_idx_q, prev_idx_d;
  logic [IDX_W-1:0]    next_idx_q, next_idx_d;
  logic                prev_ok_q, prev_ok_d;
  logic                next_ok_q, next_ok_d;
  logic                qry_ok_q, qry_ok_d;
  logic [STAMP_W-1:0]  hold_delta_q, hold_delta_d;
  logic                hold_seen_q, hold_seen_d;
  logic                out_valid_q, out_valid_d;
  logic [STAMP_W-1:0]  out_oncpu_q, out_oncpu_d;
  logic                out_oseen_q, out_oseen_d;
  logic [STAMP_W-1:0]  out_runq_q, out_runq_d;
  logic                out_rseen_q, out_rseen_d;
  logic                out_found_q, out_found_d;
  logic [CNT_W-1:0]    out_sw_q, out_sw_d;
  logic [STAMP_W-1:0]  out_total_q, out_total_d;
  logic [STAMP_W-1:0]  out_last_q, out_last_d;

  mem_ctl_t            ctl;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  stamp_entry_t        stamp_wd;
  stat_entry_t         stat_wd;
  logic [STAMP_W-1:0]  delta_run;
  logic [STAMP_W-1:0]  delta_wait;
  logic [CNT_W-1:0]    sw_sat;
  logic                out_free;
  logic                run_seen;
  logic                wait_seen;

  assign delta_run  = now_q - stamp_rdata_i.run_stamp;
  assign delta_wait = now_q - stamp_rdata_i.wait_stamp;
  assign sw_sat     = (stat_rdata_i.switches == '1) ? stat_rdata_i.switches
                                                    : stat_rdata_i.switches + CNT_W'(1);
  assign out_free   = !out_valid_q || out_ready_i;
  assign run_seen   = prev_ok_q && stamp_rdata_i.run_valid;
  assign wait_seen  = next_ok_q && stamp_rdata_i.wait_valid;

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    now_d        = now_q;
    prev_idx_d   = prev_idx_q;
    next_idx_d   = next_idx_q;
    prev_ok_d    = prev_ok_q;
    next_ok_d    = next_ok_q;
    qry_ok_d     = qry_ok_q;
    hold_delta_d = hold_delta_q;
    hold_seen_d  = hold_seen_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_oncpu_d  = out_oncpu_q;
    out_oseen_d  = out_oseen_q;
    out_runq_d   = out_runq_q;
    out_rseen_d  = out_rseen_q;
    out_found_d  = out_found_q;
    out_sw_d     = out_sw_q;
    out_total_d  = out_total_q;
    out_last_d   = out_last_q;
    ctl          = '0;
    rd_addr      = prev_idx_q;
    wr_addr      = clr_idx_q;
    stamp_wd     = '0;
    stat_wd      = '0;

    unique case (state_q)
      ST_CLEAR: begin
        // zero every entry, valid bits included
        ctl.stamp_we = 1'b1;
        ctl.stat_we  = 1'b1;
        if (clr_idx_q == IDX_W'(TASK_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          ctl.rd_en  = 1'b1;
          now_d      = now_ns_i;
          prev_idx_d = id_to_idx(prev_task_i);
          next_idx_d = id_to_idx(next_task_i);
          prev_ok_d  = (prev_task_i != '0) && id_in_range(prev_task_i);
          next_ok_d  = (next_task_i != '0) && id_in_range(next_task_i);
          qry_ok_d   = id_in_range(query_task_i);
          if (req_type_i == REQ_QUERY) begin
            rd_addr = id_to_idx(query_task_i);
            state_d = ST_QRY_WB;
          end else begin
            rd_addr = id_to_idx(prev_task_i);
            state_d = ST_PREV_WB;
          end
        end
      end

      ST_PREV_WB: begin
        wr_addr             = prev_idx_q;
        ctl.stamp_we        = prev_ok_q;
        stamp_wd.run_valid  = 1'b0;
        stamp_wd.run_stamp  = stamp_rdata_i.run_stamp;
        stamp_wd.wait_valid = 1'b1;
        stamp_wd.wait_stamp = now_q;
        ctl.stat_we         = run_seen;
        if (stat_rdata_i.valid) begin
          stat_wd.valid     = 1'b1;
          stat_wd.switches  = sw_sat;
          stat_wd.run_total = stat_rdata_i.run_total + delta_run;
          stat_wd.last_wait = stat_rdata_i.last_wait;
        end else begin
          stat_wd.valid     = 1'b1;
          stat_wd.switches  = CNT_W'(1);
          stat_wd.run_total = delta_run;
          stat_wd.last_wait = '0;
        end
        hold_delta_d = run_seen ? delta_run : '0;
        hold_seen_d  = run_seen;
        state_d      = ST_NEXT_RD;
      end

      ST_NEXT_RD: begin
        // prev write-back has landed, so a same-task read sees it
        ctl.rd_en = 1'b1;
        rd_addr   = next_idx_q;
        state_d   = ST_NEXT_WB;
      end

      ST_NEXT_WB: begin
        wr_addr = next_idx_q;
        if (out_free) begin
          ctl.stamp_we        = next_ok_q;
          stamp_wd.run_valid  = 1'b1;
          stamp_wd.run_stamp  = now_q;
          stamp_wd.wait_valid = 1'b0;
          stamp_wd.wait_stamp = stamp_rdata_i.wait_stamp;
          ctl.stat_we         = wait_seen && stat_rdata_i.valid;
          stat_wd             = stat_rdata_i;
          stat_wd.last_wait   = delta_wait;
          out_valid_d = 1'b1;
          out_oncpu_d = hold_delta_q;
          out_oseen_d = hold_seen_q;
          out_runq_d  = wait_seen ? delta_wait : '0;
          out_rseen_d = wait_seen;
          out_found_d = 1'b0;
          out_sw_d    = '0;
          out_total_d = '0;
          out_last_d  = '0;
          state_d     = ST_IDLE;
        end
      end

      ST_QRY_WB: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_oncpu_d = '0;
          out_oseen_d = 1'b0;
          out_runq_d  = '0;
          out_rseen_d = 1'b0;
          if (qry_ok_q && stat_rdata_i.valid) begin
            out_found_d = 1'b1;
            out_sw_d    = stat_rdata_i.switches;
            out_total_d = stat_rdata_i.run_total;
            out_last_d  = stat_rdata_i.last_wait;
          end else begin
            out_found_d = 1'b0;
            out_sw_d    = '0;
            out_total_d = '0;
            out_last_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      now_q        <= '0;
      prev_idx_q   <= '0;
      next_idx_q   <= '0;
      prev_ok_q    <= 1'b0;
      next_ok_q    <= 1'b0;
      qry_ok_q     <= 1'b0;
      hold_delta_q <= '0;
      hold_seen_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_oncpu_q  <= '0;
      out_oseen_q  <= 1'b0;
      out_runq_q   <= '0;
      out_rseen_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_sw_q     <= '0;
      out_total_q  <= '0;
      out_last_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      now_q        <= now_d;
      prev_idx_q   <= prev_idx_d;
      next_idx_q   <= next_idx_d;
      prev_ok_q    <= prev_ok_d;
      next_ok_q    <= next_ok_d;
      qry_ok_q     <= qry_ok_d;
      hold_delta_q <= hold_delta_d;
      hold_seen_q  <= hold_seen_d;
      out_valid_q  <= out_valid_d;
      out_oncpu_q  <= out_oncpu_d;
      out_oseen_q  <= out_oseen_d;
      out_runq_q   <= out_runq_d;
      out_rseen_q  <= out_rseen_d;
      out_found_q  <= out_found_d;
      out_sw_q     <= out_sw_d;
      out_total_q  <= out_total_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign oncpu_delta_o      = out_oncpu_q;
  assign oncpu_seen_o       = out_oseen_q;
  assign runq_delta_o       = out_runq_q;
  assign runq_seen_o        = out_rseen_q;
  assign stat_found_o       = out_found_q;
  assign stat_switches_o    = out_sw_q;
  assign stat_oncpu_total_o = out_total_q;
  assign stat_last_runq_o   = out_last_q;

  assign mem_ctl_o     = ctl;
  assign rd_addr_o     = rd_addr;
  assign wr_addr_o     = wr_addr;
  assign stamp_wdata_o = stamp_wd;
  assign stat_wdata_o  = stat_wd;

  // reads and write-backs never share a cycle, so no read sees a stale entry
  `ASSERT_ALWAYS(a_no_rw_overlap, !(ctl.rd_en && (ctl.stamp_we || ctl.stat_we)),
                 "memory read issued in a write-back cycle")
  `ASSERT_NEXT(a_prev_then_next, state_q == ST_PREV_WB, state_q == ST_NEXT_RD,
               "incoming-task read did not follow outgoing write-back")
  `ASSERT_IMPLIES(a_result_from_wb, $rose(out_valid_q),
                  $past(state_q == ST_NEXT_WB) || $past(state_q == ST_QRY_WB),
                  "result loaded outside a completion state")
  `ASSERT_IMPLIES(a_stat_entry_sane, ctl.stat_we && state_q != ST_CLEAR,
                  stat_wd.valid && stat_wd.switches != '0,
                  "statistics write-back without a live entry")

endmodule

`default_nettype wire

// ----- src/per_task_cpu_time_accounting_unit.sv -----
// ----------------------------------------------------------------------------
// per_task_cpu_time_accounting_unit
// Per-task on-CPU time and runqueue latency accounting over two task-indexed
// memories: stamps and statistics.
// ----------------------------------------------------------------------------
//   channel   handshake               payload
//   request   in_valid_i / in_ready_o   req_type, now_ns, prev/next/query_task
//   result    out_valid_o / out_ready_i oncpu_*, runq_*, stat_*
//
// A switch transaction: accept with read of the outgoing entry, its write-back,
// read of the incoming entry, its write-back. A query: accept with read of its
// entry, then the result. The read-modify-write on the single-write-port
// memories sets this order. After reset a clearing pass over all TASK_SLOTS
// entries zeroes both memories; no request is accepted meanwhile. A result
// held in the output register stalls only the last step of the next transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module per_task_cpu_time_accounting_unit #(
  parameter int unsigned TASK_SLOTS = ptcta_pkg::TASK_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ptcta_pkg::STAMP_W-1:0] now_ns_i,
  input  logic [ptcta_pkg::ID_W-1:0]    prev_task_i,
  input  logic [ptcta_pkg::ID_W-1:0]    next_task_i,
  input  logic [ptcta_pkg::ID_W-1:0]    query_task_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptcta_pkg::STAMP_W-1:0] oncpu_delta_o,
  output logic                          oncpu_seen_o,
  output logic [ptcta_pkg::STAMP_W-1:0] runq_delta_o,
  output logic                          runq_seen_o,
  output logic                          stat_found_o,
  output logic [ptcta_pkg::CNT_W-1:0]   stat_switches_o,
  output logic [ptcta_pkg::STAMP_W-1:0] stat_oncpu_total_o,
  output logic [ptcta_pkg::STAMP_W-1:0] stat_last_runq_o
);

  import ptcta_pkg::*;

  localparam int unsigned IDX_W = $clog2(TASK_SLOTS);

  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  stamp_entry_t     stamp_wdata;
  stamp_entry_t     stamp_rdata;
  stat_entry_t      stat_wdata;
  stat_entry_t      stat_rdata;

  ptcta_ctrl #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .now_ns_i          (now_ns_i),
    .prev_task_i       (prev_task_i),
    .next_task_i       (next_task_i),
    .query_task_i      (query_task_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .oncpu_delta_o     (oncpu_delta_o),
    .oncpu_seen_o      (oncpu_seen_o),
    .runq_delta_o      (runq_delta_o),
    .runq_seen_o       (runq_seen_o),
    .stat_found_o      (stat_found_o),
    .stat_switches_o   (stat_switches_o),
    .stat_oncpu_total_o(stat_oncpu_total_o),
    .stat_last_runq_o  (stat_last_runq_o),
    .mem_ctl_o         (mem_ctl),
    .rd_addr_o         (rd_addr),
    .wr_addr_o         (wr_addr),
    .stamp_wdata_o     (stamp_wdata),
    .stat_wdata_o      (stat_wdata),
    .stamp_rdata_i     (stamp_rdata),
    .stat_rdata_i      (stat_rdata)
  );

  ptcta_ram #(
    .DEPTH(TASK_SLOTS),
    .WIDTH($bits(stamp_entry_t))
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (mem_ctl.stamp_we),
    .waddr_i(wr_addr),
    .wdata_i(stamp_wdata),
    .re_i   (mem_ctl.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(stamp_rdata)
  );

  ptcta_ram #(
    .DEPTH(TASK_SLOTS),
    .WIDTH($bits(stat_entry_t))
  ) u_stat_ram (
    .clk_i  (clk_i),
    .we_i   (mem_ctl.stat_we),
    .waddr_i(wr_addr),
    .wdata_i(stat_wdata),
    .re_i   (mem_ctl.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(stat_rdata)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for per_task_cpu_time_accounting_unit. Context switch events and
// statistics reads are driven through the request channel. A scoreboard keeps
// its own per-task stamp and statistics tables and works out every result. The
// results are checked in order, field by field. Directed cases come first, then
// an output stall that backs up the request side, then scheduler-like random
// traffic under three idling profiles.
// ----------------------------------------------------------------------------
module testbench;
  import ptcta_pkg::*;

  localparam int unsigned SLOTS       = TASK_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] now;
    logic [ID_W-1:0]    prev;
    logic [ID_W-1:0]    next;
    logic [ID_W-1:0]    query;
  } sched_req_t;

  typedef struct packed {
    logic [STAMP_W-1:0] oncpu_delta;
    logic               oncpu_seen;
    logic [STAMP_W-1:0] runq_delta;
    logic               runq_seen;
    logic               stat_found;
    logic [CNT_W-1:0]   stat_switches;
    logic [STAMP_W-1:0] stat_oncpu_total;
    logic [STAMP_W-1:0] stat_last_runq;
  } acct_result_t;

  logic               clk_i;
  logic               rst_ni       = 1'b1;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic               req_type_i   = REQ_SWITCH;
  logic [STAMP_W-1:0] now_ns_i     = '0;
  logic [ID_W-1:0]    prev_task_i  = '0;
  logic [ID_W-1:0]    next_task_i  = '0;
  logic [ID_W-1:0]    query_task_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [STAMP_W-1:0] oncpu_delta_o;
  logic               oncpu_seen_o;
  logic [STAMP_W-1:0] runq_delta_o;
  logic               runq_seen_o;
  logic               stat_found_o;
  logic [CNT_W-1:0]   stat_switches_o;
  logic [STAMP_W-1:0] stat_oncpu_total_o;
  logic [STAMP_W-1:0] stat_last_runq_o;

  per_task_cpu_time_accounting_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .now_ns_i           (now_ns_i),
    .prev_task_i        (prev_task_i),
    .next_task_i        (next_task_i),
    .query_task_i       (query_task_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .oncpu_delta_o      (oncpu_delta_o),
    .oncpu_seen_o       (oncpu_seen_o),
    .runq_delta_o       (runq_delta_o),
    .runq_seen_o        (runq_seen_o),
    .stat_found_o       (stat_found_o),
    .stat_switches_o    (stat_switches_o),
    .stat_oncpu_total_o (stat_oncpu_total_o),
    .stat_last_runq_o   (stat_last_runq_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // scoreboard copy of the per-task tables
  bit                 run_ok    [SLOTS];
  logic [STAMP_W-1:0] run_at    [SLOTS];
  bit                 queued_ok [SLOTS];
  logic [STAMP_W-1:0] queued_at [SLOTS];
  bit                 stat_ok   [SLOTS];
  logic [CNT_W-1:0]   stat_cnt  [SLOTS];
  logic [STAMP_W-1:0] stat_sum  [SLOTS];
  logic [STAMP_W-1:0] stat_lat  [SLOTS];

  acct_result_t pending_acct[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int ready_hold_req;
  int ready_hold_left;
  int errors;
  int cycle_count;
  int n_switch, n_query, n_checked, n_oncpu, n_runq, n_found;

  // scheduler state of the random traffic
  logic [STAMP_W-1:0] clock_ns;
  logic [ID_W-1:0]    cpu_task;

  function automatic bit task_tracked(input logic [ID_W-1:0] id);
    return id != '0 && 32'(id) < SLOTS;
  endfunction

  function automatic acct_result_t account_request(input sched_req_t r);
    acct_result_t       res;
    logic [STAMP_W-1:0] d;
    res = '0;
    if (r.kind == REQ_QUERY) begin
      if (32'(r.query) < SLOTS && stat_ok[r.query]) begin
        res.stat_found       = 1'b1;
        res.stat_switches    = stat_cnt[r.query];
        res.stat_oncpu_total = stat_sum[r.query];
        res.stat_last_runq   = stat_lat[r.query];
      end
    end else begin
      // outgoing side first, so a task on both sides sees its fresh enqueue stamp
      if (task_tracked(r.prev)) begin
        if (run_ok[r.prev]) begin
          d = r.now - run_at[r.prev];
          res.oncpu_delta = d;
          res.oncpu_seen  = 1'b1;
          if (stat_ok[r.prev]) begin
            if (stat_cnt[r.prev] != '1) stat_cnt[r.prev] = stat_cnt[r.prev] + CNT_W'(1);
            stat_sum[r.prev] = stat_sum[r.prev] + d;
          end else begin
            stat_ok[r.prev]  = 1'b1;
            stat_cnt[r.prev] = 1;
            stat_sum[r.prev] = d;
            stat_lat[r.prev] = '0;
          end
          run_ok[r.prev] = 1'b0;
        end
        queued_ok[r.prev] = 1'b1;
        queued_at[r.prev] = r.now;
      end
      if (task_tracked(r.next)) begin
        if (queued_ok[r.next]) begin
          d = r.now - queued_at[r.next];
          res.runq_delta = d;
          res.runq_seen  = 1'b1;
          if (stat_ok[r.next]) stat_lat[r.next] = d;
          queued_ok[r.next] = 1'b0;
        end
        run_ok[r.next] = 1'b1;
        run_at[r.next] = r.now;
      end
    end
    return res;
  endfunction

  // mostly a small working set, now and then any id, the top id or none
  function automatic logic [ID_W-1:0] pick_task();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return ID_W'($urandom_range(1, 12));
    if (sel < 90) return ID_W'($urandom);
    if (sel < 95) return '1;
    return '0;
  endfunction

  // called just after a rising edge; returns at the edge that takes the transaction
  task automatic offer_request(input sched_req_t r);
    int           gap;
    acct_result_t res;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= r.kind;
    now_ns_i     <= r.now;
    prev_task_i  <= r.prev;
    next_task_i  <= r.next;
    query_task_i <= r.query;
    do @(posedge clk_i); while (!in_ready_o);
    res = account_request(r);
    pending_acct.push_back(res);
    if (r.kind == REQ_QUERY) n_query++;
    else n_switch++;
    if (res.oncpu_seen) n_oncpu++;
    if (res.runq_seen) n_runq++;
    if (res.stat_found) n_found++;
  endtask

  task automatic send_switch(input logic [STAMP_W-1:0] now,
                             input logic [ID_W-1:0] prev, input logic [ID_W-1:0] next);
    sched_req_t r;
    r.kind  = REQ_SWITCH;
    r.now   = now;
    r.prev  = prev;
    r.next  = next;
    r.query = ID_W'($urandom);
    offer_request(r);
  endtask

  // fields a read does not use carry noise
  task automatic send_query(input logic [ID_W-1:0] id);
    sched_req_t r;
    r.kind  = REQ_QUERY;
    r.now   = {$urandom, $urandom};
    r.prev  = ID_W'($urandom);
    r.next  = ID_W'($urandom);
    r.query = id;
    offer_request(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    acct_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_acct.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
      end else begin
        want = pending_acct.pop_front();
        n_checked++;
        check_field("oncpu_delta", want.oncpu_delta, oncpu_delta_o);
        check_field("oncpu_seen", 64'(want.oncpu_seen), 64'(oncpu_seen_o));
        check_field("runq_delta", want.runq_delta, runq_delta_o);
        check_field("runq_seen", 64'(want.runq_seen), 64'(runq_seen_o));
        check_field("stat_found", 64'(want.stat_found), 64'(stat_found_o));
        check_field("stat_switches", 64'(want.stat_switches), 64'(stat_switches_o));
        check_field("stat_oncpu_total", want.stat_oncpu_total, stat_oncpu_total_o);
        check_field("stat_last_runq", want.stat_last_runq, stat_last_runq_o);
      end
    end
  end

  // result side: random stalls, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (ready_hold_req != 0) begin
      ready_hold_left = ready_hold_req;
      ready_hold_req  = 0;
    end
    if (ready_hold_left != 0) begin
      ready_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("per_task_cpu_time_accounting_unit regression: fail");
      $finish;
    end
  end

  task automatic test_missing_stats();
    send_query('0);
    send_query('1);
    send_query(ID_W'(5));
  endtask

  task automatic test_first_switches();
    send_switch(64'd0, '0, '0);
    send_switch(64'd100, '0, ID_W'(7));
    send_switch(64'd250, ID_W'(7), ID_W'(9));   // entry for 7 created
    send_query(ID_W'(7));
    send_switch(64'd1000, ID_W'(9), ID_W'(7));  // 7 has an entry, latency stored
    send_query(ID_W'(7));
    send_query(ID_W'(9));
  endtask

  task automatic test_same_task();
    send_switch(64'd2000, ID_W'(7), ID_W'(7));
    send_query(ID_W'(7));
  endtask

  // runqueue wait measured for a task that never ran: latency is not kept
  task automatic test_wait_without_entry();
    send_switch(64'd5, ID_W'(3), '0);
    send_switch(64'd20, '0, ID_W'(3));
    send_query(ID_W'(3));
  endtask

  task automatic test_wrap_extremes();
    send_switch(64'd1, '0, '1);
    send_switch('1, '1, '0);                    // near the largest on-CPU time
    send_switch(64'd0, '0, '1);
    send_switch(64'd5, '1, '0);                 // running total wraps
    send_query('1);
    send_switch(64'd10, '0, ID_W'(2048));
    send_switch(64'd3, ID_W'(2048), '0);        // clock went backwards
    send_query(ID_W'(2048));
  endtask

  task automatic test_output_backpressure();
    logic [ID_W-1:0] nxt;
    int              saved_tx;
    saved_tx       = tx_idle_pct;
    tx_idle_pct    = 0;
    clock_ns       = 64'd50000;
    cpu_task       = '0;
    ready_hold_req = 300;
    for (int i = 0; i < 30; i++) begin
      clock_ns = clock_ns + 64'($urandom_range(1, 500));
      nxt      = pick_task();
      send_switch(clock_ns, cpu_task, nxt);
      cpu_task = nxt;
    end
    tx_idle_pct = saved_tx;
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count,
                                     input logic [STAMP_W-1:0] base);
    int              sel;
    logic [ID_W-1:0] nxt;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    clock_ns    = base;
    cpu_task    = '0;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 18) begin
        send_query(pick_task());
      end else if (sel < 88) begin
        if ($urandom_range(99) < 5) clock_ns = clock_ns + {32'h0, $urandom};
        else clock_ns = clock_ns + 64'($urandom_range(1, 3000));
        nxt = pick_task();
        send_switch(clock_ns, cpu_task, nxt);
        cpu_task = nxt;
      end else if (sel < 94) begin
        send_switch({$urandom, $urandom}, ID_W'($urandom), ID_W'($urandom));
      end else begin
        nxt = pick_task();
        send_switch(clock_ns - 64'($urandom_range(0, 50)), nxt,
                    $urandom_range(1) ? nxt : pick_task());
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    tx_idle_pct = 11;
    rx_idle_pct = 62;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_missing_stats();
    test_first_switches();
    test_same_task();
    test_wait_without_entry();
    test_wrap_extremes();
    test_output_backpressure();
    test_random_traffic(11, 62, 620, 64'hFFFF_FFFF_FFF0_0000);
    test_random_traffic(62, 11, 620, {$urandom, $urandom});
    test_random_traffic(0, 0, 620, 64'd0);
    in_valid_i <= 1'b0;

    while (pending_acct.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d context switches and %0d statistics reads, %0d results checked",
             n_switch, n_query, n_checked);
    $display("on-CPU times measured: %0d, runqueue waits measured: %0d, entries found: %0d",
             n_oncpu, n_runq, n_found);
    if (errors == 0) begin
      $display("per_task_cpu_time_accounting_unit regression: pass");
    end else begin
      $display("per_task_cpu_time_accounting_unit regression: fail");
    end
    $finish;
  end

endmodule
